@@ sv/scan_polar_to_cartesian_unit_defines.svh @@
// Assertion macros shared by the scan polar-to-Cartesian unit.
// Depends on a clock named clock and an active-high reset named reset in scope.
`ifndef SCAN_POLAR_TO_CARTESIAN_UNIT_DEFINES_SVH
`define SCAN_POLAR_TO_CARTESIAN_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SPC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SPC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/spc_pkg.sv @@
// Package of the scan polar-to-Cartesian unit: widths, constants, types.
// No dependencies.
`timescale 1ns / 1ps

package spc_pkg;

   localparam int STEP_W     = 10;
   localparam int DIST_W     = 12;
   localparam int MM_W       = 13;
   localparam int ANGLE_W    = 16;
   localparam int RES_W      = 12;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;

   localparam int MAX_STEP      = 1023;
   localparam int CORDIC_STAGES = 16;
   localparam int TABLE_LEN     = 24;
   localparam int NUM_STAGES    = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;

   // Step saturation compares on a width that holds any legal MAX_STEP.
   localparam int STEP_CMP_W = 13;
   localparam logic [STEP_CMP_W-1:0] STEP_LIMIT = STEP_CMP_W'(MAX_STEP);

   // Inverse CORDIC gain in Q30; the magnitude product drops 14 bits to land in Q16.
   localparam int KINV_W   = 30;
   localparam logic [KINV_W-1:0] KINV_Q30 = KINV_W'(652032874);
   localparam int PROD_W   = DIST_W + KINV_W;
   localparam int MAG_DROP = 14;
   localparam int MAG_W    = PROD_W - MAG_DROP;

   localparam int VEC_W    = 32;
   localparam int FRAC_W   = 16;
   localparam int MM_LIMIT = 4095;

   localparam logic signed [VEC_W-1:0] ATAN_TURN32 [TABLE_LEN] = '{
      32'sh20000000, 32'sh12E4051E, 32'sh09FB385B, 32'sh051111D4, 32'sh028B0D43,
      32'sh0145D7E1, 32'sh00A2F61E, 32'sh00517C55, 32'sh0028BE53, 32'sh00145F2F,
      32'sh000A2F98, 32'sh000517CC, 32'sh00028BE6, 32'sh000145F3, 32'sh0000A2FA,
      32'sh0000517D, 32'sh000028BE, 32'sh0000145F, 32'sh00000A30, 32'sh00000518,
      32'sh0000028C, 32'sh00000146, 32'sh000000A3, 32'sh00000051
   };

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BEGIN_ANGLE = 4'd0,
      CSR_STEP_RES    = 4'd1
   } csr_idx_type;

   typedef struct packed {
      logic [ANGLE_W-1:0] begin_angle;
      logic [RES_W-1:0]   step_res;
   } cfg_type;

   // Rotation vector traveling down the pipeline with its echoed distance.
   typedef struct packed {
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
      logic signed [VEC_W-1:0] z;
      logic [DIST_W-1:0]       dist_mm;
   } vec_type;

endpackage

@@ sv/spc_ifs.sv @@
// Valid/ready channel interfaces of the scan polar-to-Cartesian unit.
// Depends on spc_pkg for field widths.
`timescale 1ns / 1ps

interface spc_req_if;
   logic                        valid;
   logic                        ready;
   logic [spc_pkg::STEP_W-1:0]  step_index;
   logic [spc_pkg::DIST_W-1:0]  distance_mm;
   modport source (output valid, step_index, distance_mm, input ready);
   modport sink   (input valid, step_index, distance_mm, output ready);
endinterface

interface spc_rsp_if;
   logic                             valid;
   logic                             ready;
   logic signed [spc_pkg::MM_W-1:0]  x_mm;
   logic signed [spc_pkg::MM_W-1:0]  y_mm;
   logic [spc_pkg::DIST_W-1:0]       range_mm;
   modport source (output valid, x_mm, y_mm, range_mm, input ready);
   modport sink   (input valid, x_mm, y_mm, range_mm, output ready);
endinterface

interface spc_csr_if;
   logic                            valid;
   logic                            ready;
   logic [spc_pkg::CSR_IDX_W-1:0]   index;
   logic [spc_pkg::CSR_DATA_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/spc_front.sv @@
// Front end: beam angle and scaled magnitude products, then quadrant folding.
// Depends on spc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "scan_polar_to_cartesian_unit_defines.svh"

module spc_front (
   input  logic                        clock,
   input  logic                        reset,
   input  spc_pkg::cfg_type            cfg,
   input  logic                        up_valid,
   output logic                        up_ready,
   input  logic [spc_pkg::STEP_W-1:0]  step_index,
   input  logic [spc_pkg::DIST_W-1:0]  distance_mm,
   output logic                        down_valid,
   input  logic                        down_ready,
   output spc_pkg::vec_type            down_vec
);

   logic                                      a_valid_ff;
   logic [spc_pkg::ANGLE_W-1:0]               ang_prod_ff, ang_prod_in;
   logic [spc_pkg::PROD_W-1:0]                mag_prod_ff, mag_prod_in;
   logic [spc_pkg::DIST_W-1:0]                a_dist_ff;
   logic                                      b_valid_ff;
   spc_pkg::vec_type                          b_vec_ff, b_vec_in;
   logic                                      a_ready, b_ready;
   logic [spc_pkg::STEP_W-1:0]                step_sat;
   logic [spc_pkg::RES_W+spc_pkg::STEP_W-1:0] ang_full;
   logic [spc_pkg::ANGLE_W-1:0]               ang;
   logic                                      flip;
   logic [spc_pkg::MAG_W-1:0]                 mag;
   logic signed [spc_pkg::VEC_W-1:0]          mag_ext;

   assign b_ready  = !b_valid_ff || down_ready;
   assign a_ready  = !a_valid_ff || b_ready;
   assign up_ready = a_ready;

   // Stage A: the two products.
   always_comb begin
      if ({{(spc_pkg::STEP_CMP_W-spc_pkg::STEP_W){1'b0}}, step_index} > spc_pkg::STEP_LIMIT) begin
         step_sat = spc_pkg::STEP_LIMIT[spc_pkg::STEP_W-1:0];
      end else begin
         step_sat = step_index;
      end
      ang_full    = cfg.step_res * step_sat;
      ang_prod_in = ang_full[spc_pkg::ANGLE_W-1:0];
      mag_prod_in = spc_pkg::PROD_W'(distance_mm) * spc_pkg::KINV_Q30;
   end

   // Stage B: wrap the angle and fold the left half plane onto the right.
   always_comb begin
      ang     = cfg.begin_angle + ang_prod_ff;
      flip    = ang[spc_pkg::ANGLE_W-1] ^ ang[spc_pkg::ANGLE_W-2];
      mag     = mag_prod_ff[spc_pkg::PROD_W-1:spc_pkg::MAG_DROP];
      mag_ext = $signed({{(spc_pkg::VEC_W-spc_pkg::MAG_W){1'b0}}, mag});
      b_vec_in.x    = flip ? -mag_ext : mag_ext;
      b_vec_in.y    = '0;
      b_vec_in.z    = $signed({ang[spc_pkg::ANGLE_W-1] ^ flip, ang[spc_pkg::ANGLE_W-2:0],
                                {(spc_pkg::VEC_W-spc_pkg::ANGLE_W){1'b0}}});
      b_vec_in.dist_mm = a_dist_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (a_ready) begin
            a_valid_ff <= up_valid;
         end
         if (b_ready) begin
            b_valid_ff <= a_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready) begin
         ang_prod_ff <= ang_prod_in;
         mag_prod_ff <= mag_prod_in;
         a_dist_ff   <= distance_mm;
      end
      if (b_ready) begin
         b_vec_ff <= b_vec_in;
      end
   end

   assign down_valid = b_valid_ff;
   assign down_vec   = b_vec_ff;

   `SPC_ASSERT_NEXT(a_front_take, up_valid && up_ready, a_valid_ff,
                    "accepted item did not enter the first stage")

endmodule

@@ sv/spc_cordic.sv @@
// Rotation-mode CORDIC pipeline, one micro-rotation per register stage.
// Depends on spc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "scan_polar_to_cartesian_unit_defines.svh"

module spc_cordic (
   input  logic              clock,
   input  logic              reset,
   input  logic              up_valid,
   output logic              up_ready,
   input  spc_pkg::vec_type  up_vec,
   output logic              down_valid,
   input  logic              down_ready,
   output spc_pkg::vec_type  down_vec
);

   localparam int N = spc_pkg::NUM_STAGES;

   spc_pkg::vec_type stage_ff [N];
   logic [N-1:0]     valid_ff;
   logic [N:0]       rdy;

   assign rdy[N]   = down_ready;
   assign up_ready = rdy[0];

   for (genvar i = 0; i < N; i++) begin : g_stage
      spc_pkg::vec_type         prev;
      spc_pkg::vec_type         stage_in;
      logic                     prev_valid;
      logic signed [spc_pkg::VEC_W-1:0] dx, dy;

      if (i == 0) begin : g_first
         assign prev       = up_vec;
         assign prev_valid = up_valid;
      end else begin : g_next
         assign prev       = stage_ff[i-1];
         assign prev_valid = valid_ff[i-1];
      end

      assign rdy[i] = !valid_ff[i] || rdy[i+1];

      always_comb begin
         dx = prev.y >>> i;
         dy = prev.x >>> i;
         stage_in.dist_mm = prev.dist_mm;
         if (!prev.z[spc_pkg::VEC_W-1]) begin
            stage_in.x = prev.x - dx;
            stage_in.y = prev.y + dy;
            stage_in.z = prev.z - spc_pkg::ATAN_TURN32[i];
         end else begin
            stage_in.x = prev.x + dx;
            stage_in.y = prev.y - dy;
            stage_in.z = prev.z + spc_pkg::ATAN_TURN32[i];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (rdy[i]) begin
            valid_ff[i] <= prev_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[i]) begin
            stage_ff[i] <= stage_in;
         end
      end
   end

   assign down_valid = valid_ff[N-1];
   assign down_vec   = stage_ff[N-1];

   `SPC_ASSERT_NEXT(a_cordic_hold, valid_ff[N-1] && !down_ready,
                    valid_ff[N-1] && $stable(stage_ff[N-1]),
                    "stalled last rotation stage lost or changed its item")

endmodule

@@ sv/spc_out.sv @@
// Output stage: round half up to millimetres, clamp, and hold the result item.
// Depends on spc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "scan_polar_to_cartesian_unit_defines.svh"

module spc_out (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              up_valid,
   output logic                              up_ready,
   input  spc_pkg::vec_type                  up_vec,
   output logic                              down_valid,
   input  logic                              down_ready,
   output logic signed [spc_pkg::MM_W-1:0]   x_mm,
   output logic signed [spc_pkg::MM_W-1:0]   y_mm,
   output logic [spc_pkg::DIST_W-1:0]        range_mm
);

   localparam int Q_W = spc_pkg::VEC_W - spc_pkg::FRAC_W;
   localparam logic signed [Q_W-1:0] Q_HI = Q_W'(spc_pkg::MM_LIMIT);
   localparam logic signed [Q_W-1:0] Q_LO = -Q_HI;
   localparam logic signed [spc_pkg::VEC_W-1:0] HALF = spc_pkg::VEC_W'(1 << (spc_pkg::FRAC_W-1));
   localparam logic signed [spc_pkg::MM_W-1:0] MM_HI = Q_HI[spc_pkg::MM_W-1:0];
   localparam logic signed [spc_pkg::MM_W-1:0] MM_LO = Q_LO[spc_pkg::MM_W-1:0];

   logic                              valid_ff;
   logic signed [spc_pkg::MM_W-1:0]   x_mm_ff, x_mm_in;
   logic signed [spc_pkg::MM_W-1:0]   y_mm_ff, y_mm_in;
   logic [spc_pkg::DIST_W-1:0]        range_ff;

   function automatic logic signed [spc_pkg::MM_W-1:0] to_mm(
      input logic signed [spc_pkg::VEC_W-1:0] v
   );
      logic signed [spc_pkg::VEC_W-1:0] r;
      logic signed [Q_W-1:0]            q;
      logic signed [spc_pkg::MM_W-1:0]  res;
      r = v + HALF;
      q = r[spc_pkg::VEC_W-1:spc_pkg::FRAC_W];
      if (q > Q_HI) begin
         res = Q_HI[spc_pkg::MM_W-1:0];
      end else if (q < Q_LO) begin
         res = Q_LO[spc_pkg::MM_W-1:0];
      end else begin
         res = q[spc_pkg::MM_W-1:0];
      end
      return res;
   endfunction

   assign up_ready = !valid_ff || down_ready;
   assign x_mm_in  = to_mm(up_vec.x);
   assign y_mm_in  = to_mm(up_vec.y);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready) begin
         x_mm_ff  <= x_mm_in;
         y_mm_ff  <= y_mm_in;
         range_ff <= up_vec.dist_mm;
      end
   end

   assign down_valid = valid_ff;
   assign x_mm       = x_mm_ff;
   assign y_mm       = y_mm_ff;
   assign range_mm   = range_ff;

   `SPC_ASSERT_NOW(a_out_clamp, valid_ff,
                   (x_mm_ff >= MM_LO) && (x_mm_ff <= MM_HI) &&
                   (y_mm_ff >= MM_LO) && (y_mm_ff <= MM_HI),
                   "result coordinate outside the clamp range")

endmodule

@@ sv/scan_polar_to_cartesian_unit.sv @@
// Scan polar-to-Cartesian unit: a range-scanner sample (step index, distance in millimetres)
// enters once per clock while the unit is ready; after the front, rotation and output stages
// its x, y and echoed range leave, one result item per input item. Every stage holds one item
// under a valid bit, so the unit takes one item per cycle; a stalled result blocks only the
// stages behind it that are full. The beam angle is begin_angle + step_resolution * step_index
// in units of 2^-16 turn, wrapped to one turn. Both registers reset to 0 and 64 and are written
// through the csr channel, which is always ready; write them only while no item is in flight.
// Depends on spc_pkg, the channel interfaces, spc_front, spc_cordic and spc_out.
`timescale 1ns / 1ps

module scan_polar_to_cartesian_unit (
   input  logic       clock,
   input  logic       reset,
   spc_req_if.sink    req_ch,
   spc_rsp_if.source  rsp_ch,
   spc_csr_if.sink    csr_ch
);

   spc_pkg::cfg_type  cfg_ff;
   logic              front_valid, front_ready;
   spc_pkg::vec_type  front_vec;
   logic              rot_valid, rot_ready;
   spc_pkg::vec_type  rot_vec;

   // Configuration registers. A write to an index outside the register list is dropped.
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.begin_angle <= '0;
         cfg_ff.step_res    <= spc_pkg::RES_W'(64);
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            spc_pkg::CSR_BEGIN_ANGLE: begin
               cfg_ff.begin_angle <= csr_ch.data[spc_pkg::ANGLE_W-1:0];
            end
            spc_pkg::CSR_STEP_RES: begin
               cfg_ff.step_res <= csr_ch.data[spc_pkg::RES_W-1:0];
            end
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

   // Two front stages: angle and magnitude products, then quadrant folding into the
   // start vector of the rotation.
   spc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .up_valid    (req_ch.valid),
      .up_ready    (req_ch.ready),
      .step_index  (req_ch.step_index),
      .distance_mm (req_ch.distance_mm),
      .down_valid  (front_valid),
      .down_ready  (front_ready),
      .down_vec    (front_vec)
   );

   // One micro-rotation per stage drives the residual angle toward zero.
   spc_cordic u_cordic (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (front_valid),
      .up_ready   (front_ready),
      .up_vec     (front_vec),
      .down_valid (rot_valid),
      .down_ready (rot_ready),
      .down_vec   (rot_vec)
   );

   // Rounding, clamping and the output register that parts the pipe from the consumer.
   spc_out u_out (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (rot_valid),
      .up_ready   (rot_ready),
      .up_vec     (rot_vec),
      .down_valid (rsp_ch.valid),
      .down_ready (rsp_ch.ready),
      .x_mm       (rsp_ch.x_mm),
      .y_mm       (rsp_ch.y_mm),
      .range_mm   (rsp_ch.range_mm)
   );

endmodule

@@ sim/spc_coord_checker.sv @@
// Checker for the scan polar-to-Cartesian unit: watches the three channels, predicts each result
// item with a CORDIC rotation of its own and compares it field by field.
// Depends on spc_pkg and the channel interfaces in spc_ifs.sv.
`timescale 1ns / 1ps

module spc_coord_checker (
   input  logic clock,
   input  logic reset,
   spc_req_if   req_ch,
   spc_rsp_if   rsp_ch,
   spc_csr_if   csr_ch,
   output int   mismatches,
   output int   pending
);

   typedef struct {
      logic signed [spc_pkg::MM_W-1:0] x_mm;
      logic signed [spc_pkg::MM_W-1:0] y_mm;
      logic [spc_pkg::DIST_W-1:0]      range_mm;
   } coord_type;

   localparam longint INV_GAIN_Q30   = 652032874;
   localparam int     ROT_STAGES     = (spc_pkg::CORDIC_STAGES > 24) ? 24 : spc_pkg::CORDIC_STAGES;
   localparam int     RES_AT_RESET   = 64;
   localparam int     MM_CLAMP       = 4095;

   // Arctangent of 2^-i in units of 2^-32 turn.
   localparam longint ATAN_TURN [24] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
      64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
      64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
      64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
   };

   logic [spc_pkg::ANGLE_W-1:0] cfg_begin;
   logic [spc_pkg::RES_W-1:0]   cfg_res;
   coord_type                   coord_due_q [$];

   initial mismatches = 0;

   // Round half up out of Q16 and clamp to the output range.
   function automatic logic signed [spc_pkg::MM_W-1:0] round_to_mm(input longint v);
      longint r;
      r = (v + 32768) >>> 16;
      if (r > MM_CLAMP) r = MM_CLAMP;
      if (r < -MM_CLAMP) r = -MM_CLAMP;
      return spc_pkg::MM_W'(r);
   endfunction

   function automatic coord_type rotate_sample(input logic [spc_pkg::STEP_W-1:0] step,
                                               input logic [spc_pkg::DIST_W-1:0] dist_mm);
      coord_type                   res;
      logic [spc_pkg::ANGLE_W-1:0] ang;
      int unsigned                 eff_step;
      longint                      x, y, z, dx, dy;
      eff_step = (step > spc_pkg::MAX_STEP) ? spc_pkg::MAX_STEP : step;
      ang = spc_pkg::ANGLE_W'(32'(cfg_begin) + 32'(cfg_res) * eff_step);
      x = (longint'(dist_mm) * INV_GAIN_Q30) >>> 14;
      y = 0;
      // Fold the second and third quadrants onto the first and fourth.
      if (ang >= 16'd16384 && ang < 16'd49152) begin
         x = -x;
         ang = ang - 16'd32768;
      end
      z = longint'($signed(ang)) * 65536;
      for (int i = 0; i < ROT_STAGES; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - ATAN_TURN[i];
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + ATAN_TURN[i];
         end
      end
      res.x_mm     = round_to_mm(x);
      res.y_mm     = round_to_mm(y);
      res.range_mm = dist_mm;
      return res;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      coord_type want;
      if (reset) begin
         cfg_begin = '0;
         cfg_res   = spc_pkg::RES_W'(RES_AT_RESET);
         coord_due_q.delete();
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               spc_pkg::CSR_BEGIN_ANGLE: begin
                  cfg_begin = csr_ch.data[spc_pkg::ANGLE_W-1:0];
               end
               spc_pkg::CSR_STEP_RES: begin
                  cfg_res = csr_ch.data[spc_pkg::RES_W-1:0];
               end
               default: begin
               end
            endcase
         end
         if (req_ch.valid && req_ch.ready)
            coord_due_q.push_back(rotate_sample(req_ch.step_index, req_ch.distance_mm));
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (coord_due_q.size() == 0) begin
               report_mismatch("unexpected result item, x_mm", rsp_ch.x_mm, 0);
            end else begin
               want = coord_due_q.pop_front();
               if (rsp_ch.x_mm !== want.x_mm)
                  report_mismatch("x_mm", rsp_ch.x_mm, want.x_mm);
               if (rsp_ch.y_mm !== want.y_mm)
                  report_mismatch("y_mm", rsp_ch.y_mm, want.y_mm);
               if (rsp_ch.range_mm !== want.range_mm)
                  report_mismatch("range_mm", rsp_ch.range_mm, want.range_mm);
            end
         end
      end
      pending <= coord_due_q.size();
   end

endmodule

@@ sim/tb_top.sv @@
// Top of the scan polar-to-Cartesian testbench: clock, reset, stimulus and verdict.
// Depends on spc_pkg, spc_ifs.sv, the unit scan_polar_to_cartesian_unit and spc_coord_checker.
`timescale 1ns / 1ps

module tb_top;

   // Depth of the unit's pipeline: its front stages, rotation stages and output register.
   localparam int LATENCY         = spc_pkg::NUM_STAGES + 3;
   localparam int NUM_PHASES      = 6;
   localparam int ITEMS_PER_PHASE = 125;
   localparam int MAX_GAP         = 10;
   localparam int STEP_TOP        = (1 << spc_pkg::STEP_W) - 1;
   localparam int DIST_TOP        = (1 << spc_pkg::DIST_W) - 1;

   // An index that names no register; writes to it must leave both registers alone.
   localparam logic [spc_pkg::CSR_IDX_W-1:0] CSR_IDX_UNUSED = 4'd9;

   logic clock = 1'b0;
   logic reset;

   // Idling control shared by sender and receiver. A stall starts with a chance of one in idle_odds
   // per cycle, a gap one in idle_odds per sample; idle_enable turns both off for the last phase.
   bit idle_enable;
   int idle_odds;
   int stall_left;

   int mismatches;
   int pending;

   spc_req_if req_ch ();
   spc_rsp_if rsp_ch ();
   spc_csr_if csr_ch ();

   scan_polar_to_cartesian_unit i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   spc_coord_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .csr_ch     (csr_ch),
      .mismatches (mismatches),
      .pending    (pending)
   );

   always #5 clock = ~clock;

   // Result side: ready drops in bursts of random length while idling is enabled.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b1;
         stall_left   <= 0;
      end else if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= stall_left - 1;
      end else if (idle_enable && $urandom_range(1, idle_odds) == 1) begin
         rsp_ch.ready <= 1'b0;
         stall_left   <= $urandom_range(0, MAX_GAP - 1);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Offers one sample and returns at the edge that accepts it. Valid stays high on return,
   // so back-to-back calls stream one item per cycle while the unit is ready; an optional gap comes first.
   task automatic send_sample(input logic [spc_pkg::STEP_W-1:0] step,
                              input logic [spc_pkg::DIST_W-1:0] dist_mm);
      int gap;
      if (idle_enable && $urandom_range(1, idle_odds) == 1) begin
         gap = $urandom_range(1, MAX_GAP);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.step_index  <= step;
      req_ch.distance_mm <= dist_mm;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Stops the sender and waits until every item in flight has come out, then lets the
   // pipeline settle for its full depth.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
   endtask

   // One register write. The extra edge at the end keeps valid from being lowered and
   // raised again in the same step when writes follow each other.
   task automatic write_reg(input logic [spc_pkg::CSR_IDX_W-1:0] idx,
                            input logic [spc_pkg::CSR_DATA_W-1:0] val);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= val;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      logic [spc_pkg::DIST_W-1:0] sample_dist;
      idle_enable        = 1'b1;
      idle_odds          = 4;
      reset              <= 1'b1;
      req_ch.valid       <= 1'b0;
      req_ch.step_index  <= '0;
      req_ch.distance_mm <= '0;
      csr_ch.valid       <= 1'b0;
      csr_ch.index       <= spc_pkg::CSR_BEGIN_ANGLE;
      csr_ch.data        <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part under the reset settings: begin angle 0 and 64 units per step, so
      // step 256 sits exactly on the quarter turn, 512 on the half turn and 768 on the
      // three-quarter turn where the quadrant folding switches. Full range at angle zero
      // lands right at the output limit.
      send_sample(0, 0);
      send_sample(0, DIST_TOP);
      send_sample(128, DIST_TOP);
      send_sample(255, DIST_TOP);
      send_sample(256, DIST_TOP);
      send_sample(512, DIST_TOP);
      send_sample(767, DIST_TOP);
      send_sample(768, DIST_TOP);
      send_sample(STEP_TOP, DIST_TOP);
      send_sample(STEP_TOP, 1);
      send_sample(640, 2048);
      wait_drained();

      // Largest begin angle; the step resolution write carries high bits that the unit
      // must mask off, leaving a resolution of zero. The write to an unused index must
      // change nothing.
      write_reg(spc_pkg::CSR_BEGIN_ANGLE, 16'hFFFF);
      write_reg(spc_pkg::CSR_STEP_RES, 16'hF000);
      write_reg(CSR_IDX_UNUSED, 16'h1234);
      send_sample(0, DIST_TOP);
      send_sample(STEP_TOP, DIST_TOP);
      send_sample(5, 3000);
      wait_drained();

      // Largest resolution with the angle starting on the three-quarter turn, so the
      // product of step and resolution wraps around the turn many times.
      write_reg(spc_pkg::CSR_BEGIN_ANGLE, 16'hC000);
      write_reg(spc_pkg::CSR_STEP_RES, 16'h0FFF);
      send_sample(0, DIST_TOP);
      send_sample(1, DIST_TOP);
      send_sample(STEP_TOP, DIST_TOP);
      send_sample(16, 1);
      wait_drained();

      // Random part: every phase sets both registers, the first four to corner settings
      // and the rest at random. The last phase runs with no idling on either side.
      for (int p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: begin
               write_reg(spc_pkg::CSR_BEGIN_ANGLE, 16'h0000);
               write_reg(spc_pkg::CSR_STEP_RES, 16'h0FFF);
            end
            1: begin
               write_reg(spc_pkg::CSR_BEGIN_ANGLE, 16'hFFFF);
               write_reg(spc_pkg::CSR_STEP_RES, 16'h0000);
            end
            2: begin
               write_reg(spc_pkg::CSR_BEGIN_ANGLE, 16'h4000);
               write_reg(spc_pkg::CSR_STEP_RES, 16'h0001);
            end
            3: begin
               write_reg(spc_pkg::CSR_BEGIN_ANGLE, 16'h8000);
               write_reg(spc_pkg::CSR_STEP_RES, 16'h0040);
            end
            default: begin
               write_reg(spc_pkg::CSR_BEGIN_ANGLE, spc_pkg::CSR_DATA_W'($urandom));
               write_reg(spc_pkg::CSR_STEP_RES, spc_pkg::CSR_DATA_W'($urandom));
            end
         endcase
         idle_enable = (p < NUM_PHASES - 1);
         idle_odds   = $urandom_range(2, 12);
         for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
            // Distances lean on both ends of the range now and then.
            case ($urandom_range(0, 9))
               0:       sample_dist = '0;
               1:       sample_dist = DIST_TOP;
               default: sample_dist = spc_pkg::DIST_W'($urandom);
            endcase
            send_sample(spc_pkg::STEP_W'($urandom_range(0, STEP_TOP)), sample_dist);
            // Once, in the middle of phase 2, the sender holds off until the pipeline is empty.
            if (p == 2 && i == ITEMS_PER_PHASE / 2)
               wait_drained();
         end
         wait_drained();
      end

      if (mismatches == 0 && pending == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest correct run.
   initial begin
      #2000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

@@ scan_polar_to_cartesian_unit.f @@
+incdir+sv
sv/spc_pkg.sv
sv/spc_ifs.sv
sv/spc_front.sv
sv/spc_cordic.sv
sv/spc_out.sv
sv/scan_polar_to_cartesian_unit.sv
sim/spc_coord_checker.sv
sim/tb_top.sv
